FILE: hdl/p2ba_pkg.sv
package p2ba_pkg;

    // field widths fixed by the stream format
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 9;
    localparam int COORD_W   = 9;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // frame size after reset
    localparam logic [CFG_W-1:0] SIZE_RESET = 10'd512;

    // block run queue between the average stage and the output serialiser
    localparam int RUN_DEPTH = 8;
    localparam int RUN_PTR_W = 3;
    localparam int RUN_CNT_W = 4;

    // position bits of a run, in emission order
    localparam int POS_TL = 0;
    localparam int POS_TR = 1;
    localparam int POS_BL = 2;
    localparam int POS_BR = 3;
    localparam int POS_N  = 4;

    // one 2x2 block with the positions it covers
    typedef struct packed {
        logic [COORD_W-1:0] row0;
        logic [COORD_W-1:0] row1;
        logic [COORD_W-1:0] col0;
        logic [COORD_W-1:0] col1;
        logic [PIX_W-1:0]   value;
        logic [POS_N-1:0]   mask;
        logic               eof;
    } t_run;

endpackage

FILE: hdl/p2ba_ram.sv
module p2ba_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/p2ba_calc.sv
module p2ba_calc #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [p2ba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [p2ba_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [p2ba_pkg::PIX_W-1:0]          i_pixel,
    input  logic [p2ba_pkg::RUN_CNT_W-1:0]      i_run_count,
    output logic                                o_run_push,
    output p2ba_pkg::t_run                      o_run
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int EW         = ((CW > RW) ? CW : RW) + p2ba_pkg::CFG_W;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int PW         = p2ba_pkg::PIX_W;
    localparam int SW         = p2ba_pkg::SUM_W;
    localparam int KW         = p2ba_pkg::COORD_W;

    logic [p2ba_pkg::CFG_W-1:0] r_width, r_height;
    logic [CW-1:0]              r_col, n_col;
    logic [RW-1:0]              r_row, n_row;
    logic [PW-1:0]              r_prev;

    // stage b holds the accepted pixel while the line store read returns
    logic                       r_b_valid;
    logic [PW-1:0]              r_b_pixel, r_b_prev;
    logic [SW-1:0]              r_b_sum;
    logic [RW-1:0]              r_b_row;
    logic [CW-1:0]              r_b_col;
    logic                       r_b_odd_row, r_b_odd_col, r_b_last_col, r_b_last_row;

    logic [EW-1:0]              w_width, w_height, w_col_ext, w_row_ext;
    logic                       w_accept, w_odd_col, w_odd_row, w_last_col, w_last_row;
    logic [SW-1:0]              w_sum;
    logic [CW-1:0]              w_idx;
    logic                       w_ram_wr, w_ram_rd;
    logic [SW-1:0]              w_ram_wdata, w_above;
    logic [p2ba_pkg::RUN_CNT_W:0] w_used;

    // effective frame size, zero counts as one, oversize as the maximum
    always_comb begin
        w_width  = EW'(r_width);
        w_height = EW'(r_height);
        if (w_width == '0) begin
            w_width = EW'(1);
        end else if (w_width > EW'(MAX_WIDTH)) begin
            w_width = EW'(MAX_WIDTH);
        end
        if (w_height == '0) begin
            w_height = EW'(1);
        end else if (w_height > EW'(MAX_HEIGHT)) begin
            w_height = EW'(MAX_HEIGHT);
        end
    end

    // position of the incoming pixel
    assign w_col_ext  = EW'(r_col);
    assign w_row_ext  = EW'(r_row);
    assign w_odd_col  = r_col[0];
    assign w_odd_row  = r_row[0];
    assign w_last_col = (w_col_ext + EW'(1)) >= w_width;
    assign w_last_row = (w_row_ext + EW'(1)) >= w_height;
    assign w_sum      = SW'(r_prev) + SW'(i_pixel);
    assign w_idx      = r_col >> 1;

    // room check covers the run that stage b may still push
    assign w_used   = (p2ba_pkg::RUN_CNT_W + 1)'(i_run_count)
                    + (p2ba_pkg::RUN_CNT_W + 1)'(r_b_valid);
    assign o_stall  = w_used >= (p2ba_pkg::RUN_CNT_W + 1)'(p2ba_pkg::RUN_DEPTH);
    assign w_accept = i_valid && !o_stall;

    // even rows write pair sums or a lone last pixel, odd rows read them back
    assign w_ram_wr    = w_accept && !w_odd_row && (w_odd_col || w_last_col);
    assign w_ram_rd    = w_accept && w_odd_row;
    assign w_ram_wdata = w_odd_col ? w_sum : SW'(i_pixel);

    p2ba_ram #(
        .WIDTH (SW),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr),
        .i_wr_addr (w_idx[AW-1:0]),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (w_ram_rd),
        .i_rd_addr (w_idx[AW-1:0]),
        .o_rd_data (w_above)
    );

    // raster counters, wrap after the last pixel
    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (w_last_col) begin
            n_col = '0;
            n_row = w_last_row ? '0 : (r_row + RW'(1));
        end
    end

    // configuration and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= p2ba_pkg::SIZE_RESET;
            r_height <= p2ba_pkg::SIZE_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_prev   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                p2ba_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                p2ba_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_prev <= i_pixel;
        end
    end

    // stage b control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= w_accept;
        end
    end

    // stage b payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_pixel    <= i_pixel;
            r_b_prev     <= r_prev;
            r_b_sum      <= w_sum;
            r_b_row      <= r_row;
            r_b_col      <= r_col;
            r_b_odd_row  <= w_odd_row;
            r_b_odd_col  <= w_odd_col;
            r_b_last_col <= w_last_col;
            r_b_last_row <= w_last_row;
        end
    end

    logic [EW-1:0] w_b_row, w_b_col, w_b_row_m1, w_b_col_m1;
    logic [SW:0]   w_sum4, w_sum2;

    assign w_b_row    = EW'(r_b_row);
    assign w_b_col    = EW'(r_b_col);
    assign w_b_row_m1 = w_b_row - EW'(1);
    assign w_b_col_m1 = w_b_col - EW'(1);
    assign w_sum4     = (SW + 1)'(w_above) + (SW + 1)'(r_b_prev) + (SW + 1)'(r_b_pixel);
    assign w_sum2     = (SW + 1)'(w_above) + (SW + 1)'(r_b_pixel);

    // block average and the positions it covers
    always_comb begin
        o_run      = '0;
        o_run_push = 1'b0;
        priority if (!r_b_odd_row && r_b_odd_col) begin
            o_run_push = r_b_last_row;
            o_run.row0 = w_b_row[KW-1:0];
            o_run.col0 = w_b_col_m1[KW-1:0];
            o_run.col1 = w_b_col[KW-1:0];
            o_run.value = r_b_sum[SW-1:1];
            o_run.mask[p2ba_pkg::POS_TL] = 1'b1;
            o_run.mask[p2ba_pkg::POS_TR] = 1'b1;
        end else if (!r_b_odd_row && r_b_last_col) begin
            o_run_push = r_b_last_row;
            o_run.row0 = w_b_row[KW-1:0];
            o_run.col0 = w_b_col[KW-1:0];
            o_run.value = r_b_pixel;
            o_run.mask[p2ba_pkg::POS_TL] = 1'b1;
        end else if (r_b_odd_row && r_b_odd_col) begin
            o_run_push = 1'b1;
            o_run.row0 = w_b_row_m1[KW-1:0];
            o_run.row1 = w_b_row[KW-1:0];
            o_run.col0 = w_b_col_m1[KW-1:0];
            o_run.col1 = w_b_col[KW-1:0];
            o_run.value = w_sum4[PW+1:2];
            o_run.mask = '1;
        end else if (r_b_odd_row && r_b_last_col) begin
            o_run_push = 1'b1;
            o_run.row0 = w_b_row_m1[KW-1:0];
            o_run.row1 = w_b_row[KW-1:0];
            o_run.col0 = w_b_col[KW-1:0];
            o_run.value = w_sum2[PW:1];
            o_run.mask[p2ba_pkg::POS_TL] = 1'b1;
            o_run.mask[p2ba_pkg::POS_BL] = 1'b1;
        end else begin
            o_run_push = 1'b0;
        end
        o_run.eof  = r_b_last_row && r_b_last_col;
        o_run_push = o_run_push && r_b_valid;
    end

    // an accepted pixel always reaches stage b
    a_accept_to_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_cfg_wr_en) |=> r_b_valid)
        else $error("accepted pixel did not reach stage b");

    // odd row and odd column always completes a full block
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_odd_row && r_b_odd_col) |-> (o_run_push && (o_run.mask == '1)))
        else $error("full block not pushed");

    // a pushed run always covers at least one position
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_push |-> (o_run.mask != '0))
        else $error("empty run pushed");

endmodule

FILE: hdl/p2ba_emit.sv
module p2ba_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_run_push,
    input  p2ba_pkg::t_run                  i_run,
    output logic [p2ba_pkg::RUN_CNT_W-1:0]  o_run_count,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [p2ba_pkg::COORD_W-1:0]    o_out_row,
    output logic [p2ba_pkg::COORD_W-1:0]    o_out_col,
    output logic [p2ba_pkg::PIX_W-1:0]      o_value,
    output logic                            o_last_of_run,
    output logic                            o_end_of_frame
);

    localparam int KW = p2ba_pkg::COORD_W;
    localparam int NW = p2ba_pkg::POS_N;

    p2ba_pkg::t_run                  r_fifo [p2ba_pkg::RUN_DEPTH];
    logic [p2ba_pkg::RUN_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [p2ba_pkg::RUN_CNT_W-1:0]  r_count;
    logic [NW-1:0]                   r_sent;

    logic                            r_out_valid;
    logic [KW-1:0]                   r_out_row, r_out_col;
    logic [p2ba_pkg::PIX_W-1:0]      r_out_value;
    logic                            r_out_last, r_out_eof;

    p2ba_pkg::t_run                  w_head;
    logic [NW-1:0]                   w_left, w_bit, w_rest;
    logic                            w_have, w_load, w_last, w_pop;
    logic [KW-1:0]                   w_row, w_col;

    assign w_head = r_fifo[r_rd_ptr];
    assign w_left = w_head.mask & ~r_sent;
    assign w_have = r_count != '0;
    assign w_load = w_have && (!r_out_valid || !i_stall);

    // next position of the head run, in emission order
    always_comb begin
        w_bit = '0;
        w_row = w_head.row0;
        w_col = w_head.col0;
        priority if (w_left[p2ba_pkg::POS_TL]) begin
            w_bit[p2ba_pkg::POS_TL] = 1'b1;
        end else if (w_left[p2ba_pkg::POS_TR]) begin
            w_bit[p2ba_pkg::POS_TR] = 1'b1;
            w_col = w_head.col1;
        end else if (w_left[p2ba_pkg::POS_BL]) begin
            w_bit[p2ba_pkg::POS_BL] = 1'b1;
            w_row = w_head.row1;
        end else begin
            w_bit[p2ba_pkg::POS_BR] = 1'b1;
            w_row = w_head.row1;
            w_col = w_head.col1;
        end
    end

    assign w_rest = w_left & ~w_bit;
    assign w_last = w_rest == '0;
    assign w_pop  = w_load && w_last;

    // run queue storage
    always_ff @(posedge i_clk) begin
        if (i_run_push) begin
            r_fifo[r_wr_ptr] <= i_run;
        end
    end

    // run queue pointers and position tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sent   <= '0;
        end else begin
            if (i_run_push) begin
                r_wr_ptr <= r_wr_ptr + p2ba_pkg::RUN_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + p2ba_pkg::RUN_PTR_W'(1);
                r_sent   <= '0;
            end else if (w_load) begin
                r_sent <= r_sent | w_bit;
            end
            r_count <= r_count + p2ba_pkg::RUN_CNT_W'(i_run_push)
                               - p2ba_pkg::RUN_CNT_W'(w_pop);
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_row   <= w_row;
            r_out_col   <= w_col;
            r_out_value <= w_head.value;
            r_out_last  <= w_last;
            r_out_eof   <= w_last && w_head.eof;
        end
    end

    assign o_run_count    = r_count;
    assign o_valid        = r_out_valid;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_value        = r_out_value;
    assign o_last_of_run  = r_out_last;
    assign o_end_of_frame = r_out_eof;

    // queue never overflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_run_push |-> (r_count < p2ba_pkg::RUN_CNT_W'(p2ba_pkg::RUN_DEPTH)
                        || w_pop))
        else $error("run queue overflow");

    // frame end only on the last beat of a run
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eof) |-> r_out_last)
        else $error("end of frame without last of run");

    // a popped run leaves no positions marked as sent
    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_sent == '0))
        else $error("sent mask not cleared after pop");

endmodule

FILE: hdl/pixelate_2x2_block_average_top.sv
// a pixel that completes a block passes stage b, the run queue and the output register
// before its first result beat; the further beats of that block follow one a cycle unless stalled
// throughput: one pixel a cycle while the block run queue has room; the output port
// moves one beat a cycle unless stalled, so odd rows (4 beats per 2 pixels) wait on it
// reset: synchronous active low, clears counters, queue and valids, size back to 512x512
module pixelate_2x2_block_average_top #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [p2ba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [p2ba_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [p2ba_pkg::PIX_W-1:0]      i_pixel,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [p2ba_pkg::COORD_W-1:0]    o_out_row,
    output logic [p2ba_pkg::COORD_W-1:0]    o_out_col,
    output logic [p2ba_pkg::PIX_W-1:0]      o_value,
    output logic                            o_last_of_run,
    output logic                            o_end_of_frame
);

    logic                            w_run_push;
    p2ba_pkg::t_run                  w_run;
    logic [p2ba_pkg::RUN_CNT_W-1:0]  w_run_count;

    // pixel position, line store and block average
    p2ba_calc #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .i_run_count (w_run_count),
        .o_run_push  (w_run_push),
        .o_run       (w_run)
    );

    // run queue and output serialiser
    p2ba_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_run_push     (w_run_push),
        .i_run          (w_run),
        .o_run_count    (w_run_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_value        (o_value),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
